@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

@@ sv/fmsa_pkg.sv @@
package fmsa_pkg;

    localparam int unsigned DEF_MAX_BLOCKS = 64;
    localparam longint unsigned DEF_ARENA_BYTES = 65536;
    localparam int unsigned DEF_HEADER_BYTES = 32;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned LEN_W = 17;
    localparam int unsigned GAP_W = 18;
    localparam int unsigned CFG_W = 17;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    localparam logic [1:0] FIT_BEST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_USABLE = 1'b1;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic eval_final;
        logic ins_init;
        logic ins_rd;
        logic ins_new;
        logic del_init;
        logic del_rd;
        logic del_done;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic full;
        logic idx_at_count;
        logic idx_gt_pick;
        logic pend;
        logic have;
        logic found;
        logic out_free;
    } t_sts;

endpackage

@@ sv/fit_mode_segment_allocator_top.sv @@
// Channel  Direction  Handshake            Payload
// request  in         i_valid / o_stall    i_operation, i_request_size, i_free_address
// result   out        o_valid / i_stall    o_user_address, o_status
// config   in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One request at a time. Allocate: scan the blocks through the table memory read
// port, rate the last gap, then shift the upper entries and insert at gap P (no
// shift when P is the gap after the last block). Free: scan the blocks, then close
// up behind block F (no move when F is the last block).
// Reset (synchronous, active low) empties the table at once; no clearing pass.
// A result waits in the output register while i_stall is high; the next request
// is taken once the previous one has reached that register.
module fit_mode_segment_allocator_top #(
    parameter int unsigned MAX_BLOCKS = fmsa_pkg::DEF_MAX_BLOCKS,
    parameter longint unsigned ARENA_BYTES = fmsa_pkg::DEF_ARENA_BYTES,
    parameter int unsigned HEADER_BYTES = fmsa_pkg::DEF_HEADER_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [fmsa_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [fmsa_pkg::ADDR_W-1:0] i_request_size,
    input  logic [fmsa_pkg::ADDR_W-1:0] i_free_address,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fmsa_pkg::ADDR_W-1:0] o_user_address,
    output logic [1:0]                  o_status
);
    import fmsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fmsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    fmsa_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_user_address (o_user_address),
        .o_status       (o_status)
    );

endmodule

@@ sv/fmsa_datapath.sv @@
module fmsa_datapath #(
    parameter int unsigned MAX_BLOCKS = fmsa_pkg::DEF_MAX_BLOCKS,
    parameter longint unsigned ARENA_BYTES = fmsa_pkg::DEF_ARENA_BYTES,
    parameter int unsigned HEADER_BYTES = fmsa_pkg::DEF_HEADER_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [fmsa_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_operation,
    input  logic [fmsa_pkg::ADDR_W-1:0] i_request_size,
    input  logic [fmsa_pkg::ADDR_W-1:0] i_free_address,
    input  logic                        i_stall,
    input  fmsa_pkg::t_cmd              i_cmd,
    output fmsa_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output logic [fmsa_pkg::ADDR_W-1:0] o_user_address,
    output logic [1:0]                  o_status
);
    import fmsa_pkg::*;

    localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned WW = ADDR_W + LEN_W;
    localparam logic [8:0] HDR = 9'(HEADER_BYTES);
    localparam logic [GAP_W-1:0] ARENA_CAP =
        (ARENA_BYTES > 64'h1FFFF) ? GAP_W'(18'h1FFFF) : GAP_W'(ARENA_BYTES);

    logic [1:0]        r_fit_mode;
    logic [CFG_W-1:0]  r_usable;
    logic [WW-1:0]     r_mem [MAX_BLOCKS];
    logic [WW-1:0]     r_rdata;
    logic [CW-1:0]     r_count, r_idx, r_pick;
    logic [AW-1:0]     r_tgt, r_fidx;
    logic              r_sv, r_mv, r_op, r_have, r_found, r_ov;
    logic [LEN_W-1:0]  r_need;
    logic [ADDR_W-1:0] r_addr, r_out_addr;
    logic [GAP_W-1:0]  r_pick_start, r_pick_len, r_prev_end;
    logic [1:0]        r_out_status;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [WW-1:0]     wr_data;
    logic [CW-1:0]     idx_m1;
    logic [LEN_W-1:0]  n_need;
    logic [GAP_W-1:0]  lim, ev_ge, ev_gs, ev_gl;
    logic [ADDR_W-1:0] d_start;
    logic [LEN_W-1:0]  d_len;
    logic              ev_on, ev_fit, ev_better, ev_take, match;

    assign idx_m1 = r_idx - 1'b1;
    assign d_start = r_rdata[ADDR_W-1:0];
    assign d_len = r_rdata[WW-1:ADDR_W];
    assign lim = (ARENA_CAP < GAP_W'(r_usable)) ? ARENA_CAP : GAP_W'(r_usable);

    always_comb begin
        n_need = LEN_W'(i_request_size) + LEN_W'(HDR);
        if (n_need == '0) begin
            n_need = LEN_W'(1);
        end
    end

    // Gap under test: ends at the entry just read, or at the end of the usable arena.
    assign ev_gs = r_prev_end;
    assign ev_ge = i_cmd.eval_final ? lim : GAP_W'(d_start);
    assign ev_gl = (ev_ge > ev_gs) ? ev_ge - ev_gs : '0;
    assign ev_on = (r_sv && r_op == OP_ALLOC) || i_cmd.eval_final;
    assign ev_fit = (ev_gl >= GAP_W'(r_need)) &&
                    ((19'(ev_gs) + 19'(HDR)) <= 19'h0FFFF);
    always_comb begin
        if (!r_have) begin
            ev_better = 1'b1;
        end else if (r_fit_mode == FIT_BEST) begin
            ev_better = ev_gl < r_pick_len;
        end else if (r_fit_mode == FIT_WORST) begin
            ev_better = ev_gl > r_pick_len;
        end else begin
            ev_better = 1'b0;
        end
    end
    assign ev_take = ev_on && ev_fit && ev_better;
    assign match = r_sv && r_op == OP_FREE && !r_found &&
                   ((LEN_W'(d_start) + LEN_W'(HDR)) == LEN_W'(r_addr));

    always_comb begin
        rd_en = i_cmd.scan_rd || i_cmd.ins_rd || i_cmd.del_rd;
        rd_addr = i_cmd.ins_rd ? idx_m1[AW-1:0] : r_idx[AW-1:0];
        wr_en = r_mv || i_cmd.ins_new;
        wr_addr = r_mv ? r_tgt : r_pick[AW-1:0];
        wr_data = r_mv ? r_rdata : {r_need, r_pick_start[ADDR_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= '0;
            r_usable <= CFG_W'(17'h10000);
            r_count <= '0;
            r_idx <= '0;
            r_sv <= 1'b0;
            r_mv <= 1'b0;
            r_have <= 1'b0;
            r_found <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FIT_MODE: r_fit_mode <= i_cfg_data[1:0];
                    REG_USABLE:   r_usable <= i_cfg_data;
                    default:      r_usable <= r_usable;
                endcase
            end
            r_sv <= i_cmd.scan_rd;
            r_mv <= i_cmd.ins_rd || i_cmd.del_rd;
            if (i_cmd.start) begin
                r_idx <= '0;
                r_have <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_rd || i_cmd.del_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.ins_init) begin
                r_idx <= r_count;
            end
            if (i_cmd.ins_rd) begin
                r_idx <= idx_m1;
            end
            if (i_cmd.del_init) begin
                r_idx <= CW'(r_fidx) + 1'b1;
            end
            if (ev_take) begin
                r_have <= 1'b1;
            end
            if (match) begin
                r_found <= 1'b1;
            end
            if (i_cmd.ins_new) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.del_done) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_operation;
            r_need <= n_need;
            r_addr <= i_free_address;
            r_prev_end <= '0;
        end
        if (r_sv && r_op == OP_ALLOC) begin
            r_prev_end <= GAP_W'(d_start) + GAP_W'(d_len);
        end
        if (i_cmd.scan_rd || i_cmd.ins_rd) begin
            r_tgt <= r_idx[AW-1:0];
        end
        if (i_cmd.del_rd) begin
            r_tgt <= idx_m1[AW-1:0];
        end
        if (ev_take) begin
            r_pick <= i_cmd.eval_final ? r_count : CW'(r_tgt);
            r_pick_start <= ev_gs;
            r_pick_len <= ev_gl;
        end
        if (match) begin
            r_fidx <= r_tgt;
        end
        if (i_cmd.load_out) begin
            if (r_op == OP_ALLOC) begin
                r_out_status <= r_have ? ST_OK : ST_NOSPACE;
                r_out_addr <= r_have ? r_pick_start[ADDR_W-1:0] + ADDR_W'(HDR) : '0;
            end else begin
                r_out_status <= r_found ? ST_OK : ST_BADADDR;
                r_out_addr <= '0;
            end
        end
    end

    always_comb begin
        o_sts.op = r_op;
        o_sts.full = r_count >= CW'(MAX_BLOCKS);
        o_sts.idx_at_count = r_idx == r_count;
        o_sts.idx_gt_pick = r_idx > r_pick;
        o_sts.pend = r_sv || r_mv;
        o_sts.have = r_have;
        o_sts.found = r_found;
        o_sts.out_free = !r_ov || !i_stall;
    end

    assign o_valid = r_ov;
    assign o_user_address = r_out_addr;
    assign o_status = r_out_status;

endmodule

@@ sv/fmsa_ctrl.sv @@
module fmsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fmsa_pkg::t_sts i_sts,
    output fmsa_pkg::t_cmd o_cmd,
    output logic           o_stall
);
    import fmsa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_INS = 3'd4;
    localparam logic [2:0] S_DEL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.op == OP_ALLOC && i_sts.full) begin
                    n_state = S_DONE;
                end else if (!i_sts.idx_at_count) begin
                    o_cmd.scan_rd = 1'b1;
                end else if (!i_sts.pend) begin
                    if (i_sts.op == OP_ALLOC) begin
                        n_state = S_FINAL;
                    end else if (i_sts.found) begin
                        o_cmd.del_init = 1'b1;
                        n_state = S_DEL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FINAL: begin
                o_cmd.eval_final = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.have) begin
                    o_cmd.ins_init = 1'b1;
                    n_state = S_INS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                // shift upper entries up one, then drop the new block in
                if (i_sts.idx_gt_pick) begin
                    o_cmd.ins_rd = 1'b1;
                end else if (!i_sts.pend) begin
                    o_cmd.ins_new = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DEL: begin
                if (!i_sts.idx_at_count) begin
                    o_cmd.del_rd = 1'b1;
                end else if (!i_sts.pend) begin
                    o_cmd.del_done = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

endmodule

@@ sv/fmsa_checker.sv @@
`include "assert_macros.svh"

module fmsa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [fmsa_pkg::ADDR_W-1:0] o_user_address,
    input logic [1:0]                  o_status
);
    import fmsa_pkg::*;

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_user_address) && $stable(o_status))
    `ASSERT_IMP(a_fail_zero_addr, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_user_address == '0)
    `ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_status == ST_OK || o_status == ST_NOSPACE || o_status == ST_BADADDR)
    `ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

bind fit_mode_segment_allocator_top fmsa_checker u_fmsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_user_address (o_user_address),
    .o_status       (o_status)
);

@@ bench/fit_mode_segment_allocator_checker.sv @@
`timescale 1ns / 1ps

module fit_mode_segment_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_req_stall,
    input  logic        i_operation,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_free_address,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [15:0] i_user_address,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import fmsa_pkg::*;

    localparam int NBLK = 64;
    localparam int HDR = 32;
    localparam longint ARENA = 65536;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_alloc_result;

    logic [1:0]  mode;
    logic [16:0] usable;
    logic [15:0] seg_start [NBLK];
    logic [16:0] seg_len [NBLK];
    int          seg_count;
    t_alloc_result expected_q [$];

    function automatic t_alloc_result serve_request(logic op, logic [15:0] size,
                                                    logic [15:0] addr);
        t_alloc_result r;
        longint need, lim, gs, ge, gl, pick_start, pick_len;
        int pick, g, k;
        bit have, better, found;
        r.addr = '0;
        r.status = ST_OK;
        if (op == OP_FREE) begin
            found = 0;
            for (g = 0; g < seg_count; g++) begin
                if (longint'(seg_start[g]) + HDR == longint'(addr)) begin
                    for (k = g; k + 1 < seg_count; k++) begin
                        seg_start[k] = seg_start[k+1];
                        seg_len[k] = seg_len[k+1];
                    end
                    seg_count--;
                    found = 1;
                    break;
                end
            end
            if (!found) r.status = ST_BADADDR;
            return r;
        end
        need = longint'(size) + HDR;
        if (need == 0) need = 1;
        lim = (longint'(usable) < ARENA) ? longint'(usable) : ARENA;
        if (seg_count >= NBLK) begin
            r.status = ST_NOSPACE;
            return r;
        end
        have = 0; pick = 0; pick_start = 0; pick_len = 0;
        for (g = 0; g <= seg_count; g++) begin
            gs = (g == 0) ? 0 : longint'(seg_start[g-1]) + longint'(seg_len[g-1]);
            ge = (g == seg_count) ? lim : longint'(seg_start[g]);
            gl = (ge > gs) ? ge - gs : 0;
            if (gl < need || gs + HDR > 65535) continue;
            if (!have) better = 1;
            else if (mode == FIT_BEST) better = gl < pick_len;
            else if (mode == FIT_WORST) better = gl > pick_len;
            else better = 0;
            if (better) begin
                have = 1; pick = g; pick_start = gs; pick_len = gl;
                if (mode != FIT_BEST && mode != FIT_WORST) break;
            end
        end
        if (have) begin
            for (k = seg_count; k > pick; k--) begin
                seg_start[k] = seg_start[k-1];
                seg_len[k] = seg_len[k-1];
            end
            seg_start[pick] = pick_start[15:0];
            seg_len[pick] = need[16:0];
            seg_count++;
            r.addr = 16'(pick_start + HDR);
        end else begin
            r.status = ST_NOSPACE;
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            mode <= 2'd0;
            usable <= 17'd65536;
            seg_count = 0;
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIT_MODE) mode <= i_cfg_data[1:0];
                else usable <= i_cfg_data;
            end
            if (i_valid && !i_req_stall)
                expected_q.insert(expected_q.size(),
                                  serve_request(i_operation, i_request_size,
                                                i_free_address));
            if (i_res_valid && !i_res_stall) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result addr=%h status=%0d", $time,
                             i_user_address, i_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.addr !== i_user_address || want.status !== i_status) begin
                        $display("%0t: mismatch expected addr=%h status=%0d %s%h %s%0d",
                                 $time, want.addr, want.status, "actual addr=",
                                 i_user_address, "status=", i_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/fit_mode_segment_allocator_top_tb.sv @@
`timescale 1ns / 1ps

module fit_mode_segment_allocator_top_tb;
    import fmsa_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [16:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        operation = 1'b0;
    logic [15:0] request_size = '0;
    logic [15:0] free_address = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [15:0] user_address;
    logic [1:0]  status;
    int          errors, pending, results;

    bit          quiet = 0;
    bit          hold_off = 0;
    logic [15:0] issued_q [$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fit_mode_segment_allocator_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(req_valid), .o_stall(req_stall),
        .i_operation(operation), .i_request_size(request_size),
        .i_free_address(free_address), .o_valid(res_valid), .i_stall(res_stall),
        .o_user_address(user_address), .o_status(status)
    );

    fit_mode_segment_allocator_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(req_valid), .i_req_stall(req_stall),
        .i_operation(operation), .i_request_size(request_size),
        .i_free_address(free_address), .i_res_valid(res_valid),
        .i_res_stall(res_stall), .i_user_address(user_address), .i_status(status),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Remember granted addresses so frees mostly hit live blocks.
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall && status == ST_OK && user_address != 0)
            issued_q.insert(issued_q.size(), user_address);

    // Receiver: random stall bursts, or a long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                res_stall <= 1'b1;
                repeat (400) @(posedge clk);
                res_stall <= 1'b0;
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 6);
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_and_wait();
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_request(logic op, logic [15:0] size, logic [15:0] addr);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        request_size <= size;
        free_address <= addr;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic random_request();
        int pick;
        logic [15:0] sz;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 3))
                0: sz = 16'($urandom_range(0, 64));
                1: sz = 16'($urandom_range(0, 2000));
                2: sz = 16'($urandom_range(0, 8000));
                default: sz = 16'($urandom);
            endcase
            send_request(OP_ALLOC, sz, 16'($urandom));
        end else if (pick < 90 && issued_q.size() != 0) begin
            pick = $urandom_range(0, issued_q.size() - 1);
            send_request(OP_FREE, 16'($urandom), issued_q[pick]);
            issued_q.delete(pick);
        end else begin
            send_request(OP_FREE, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic end_transfers();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        #40_000_000;
        $display("FAIL fit_mode_segment_allocator_top");
        $finish;
    end

    initial begin
        int i, phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, empty request, unknown free, table full.
        send_request(OP_ALLOC, 16'hFFFF, 16'h0000);
        send_request(OP_ALLOC, 16'hFFDF, 16'hFFFF);
        send_request(OP_FREE, 16'h0000, 16'h0020);
        send_request(OP_ALLOC, 16'd0, 16'h0);
        send_request(OP_ALLOC, 16'd100, 16'h0);
        send_request(OP_FREE, 16'hFFFF, 16'hFFFF);
        send_request(OP_FREE, 16'h0, 16'h0021);
        send_request(OP_ALLOC, 16'hFF00, 16'h0);
        // Empty the table again.
        send_request(OP_FREE, 16'h0, 16'h0020);
        send_request(OP_FREE, 16'h0, 16'h0040);
        send_request(OP_FREE, 16'h0, 16'h00C4);
        end_transfers();
        drain_and_wait();
        write_reg(REG_USABLE, 17'd0);
        send_request(OP_ALLOC, 16'd0, 16'h0);
        end_transfers();
        drain_and_wait();
        write_reg(REG_USABLE, 17'h1FFFF);
        for (i = 0; i < 70; i++) send_request(OP_ALLOC, 16'd4, 16'h0);
        // Open a small hole at the bottom.
        send_request(OP_FREE, 16'h0, 16'h0020);
        end_transfers();
        drain_and_wait();
        // Shrink below live blocks, then free everything.
        write_reg(REG_USABLE, 17'd100);
        send_request(OP_ALLOC, 16'd10, 16'h0);
        end_transfers();
        drain_and_wait();
        issued_q.delete();
        for (i = 0; i < 64; i++) send_request(OP_FREE, 16'h0, 16'(i * 36 + 32));
        end_transfers();
        drain_and_wait();

        for (phase = 0; phase < 8; phase++) begin
            write_reg(REG_FIT_MODE, 17'(phase % 4));
            case (phase % 3)
                0: write_reg(REG_USABLE, 17'd65536);
                1: write_reg(REG_USABLE, 17'($urandom_range(256, 65536)));
                default: write_reg(REG_USABLE, 17'h1FFFF);
            endcase
            if (phase == 2) hold_off = 1;
            if (phase == 7) quiet = 1;
            for (i = 0; i < 200; i++) random_request();
            if (phase == 4) begin
                // Pause until every result is back.
                end_transfers();
                while (pending != 0) @(posedge clk);
            end
            end_transfers();
            drain_and_wait();
            // Release every block still held.
            while (issued_q.size() != 0) begin
                send_request(OP_FREE, 16'h0, issued_q[0]);
                issued_q.delete(0);
            end
            end_transfers();
            drain_and_wait();
        end

        $display("Covered all fit modes incl. unused code, arena sizes 0..max, full table,");
        $display("unknown frees and back-pressure; %0d results checked.", results);
        if (errors == 0) begin
            $display("PASS fit_mode_segment_allocator_top");
        end else begin
            $display("FAIL fit_mode_segment_allocator_top");
        end
        $finish;
    end
endmodule
